// ----- rtl/arr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arr_pkg
// Shared types and constants of the aspect ratio reducer.
// ----------------------------------------------------------------------------
package arr_pkg;

    localparam int ARR_MAX_TERM = 21;
    localparam int ARR_DW       = 16;
    localparam int PCT_SCALE    = 100;
    localparam int PCT_W        = 7;

    localparam logic [1:0] ST_EXACT  = 2'd0;
    localparam logic [1:0] ST_APPROX = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    typedef struct packed {
        logic              start;
        logic [ARR_DW-1:0] dividend;
        logic [ARR_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [ARR_DW-1:0] quot;
        logic [ARR_DW-1:0] rem;
    } t_div_rsp;

endpackage : arr_pkg
`default_nettype wire

// ----- rtl/arr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arr_div
// Iterative restoring divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module arr_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  arr_pkg::t_div_req i_req,
    output arr_pkg::t_div_rsp o_rsp
);
    import arr_pkg::*;

    localparam int CNT_W = $clog2(ARR_DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [ARR_DW-1:0] r_rem;
    logic [ARR_DW-1:0] r_quo;
    logic [ARR_DW-1:0] r_den;

    logic [ARR_DW:0]   shifted;
    logic [ARR_DW:0]   trial;
    logic [ARR_DW-1:0] n_rem;
    logic [ARR_DW-1:0] n_quo;

    always_comb begin
        shifted = {r_rem, r_quo[ARR_DW-1]};
        trial   = shifted - {1'b0, r_den};
        if (!trial[ARR_DW]) begin
            n_rem = trial[ARR_DW-1:0];
            n_quo = {r_quo[ARR_DW-2:0], 1'b1};
        end else begin
            n_rem = shifted[ARR_DW-1:0];
            n_quo = {r_quo[ARR_DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ARR_DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule : arr_div
`default_nettype wire

// ----- rtl/aspect_ratio_reducer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aspect_ratio_reducer_unit
// Reduces a width x height resolution to an aspect ratio by Euclid's GCD,
// with a bounded search for a small ratio within one percent.
// ----------------------------------------------------------------------------
// One transaction carries a resolution and yields one ratio transaction.
// The block takes one resolution at a time and is not ready while working.
// A zero dimension goes straight to the finish state. Otherwise every modulo
// step of Euclid and each of the two final divisions runs on one shared
// 16-bit restoring divider; Euclid takes up to about 23 modulo steps for
// 16-bit inputs. When the reduced width exceeds MAX_TERM, the candidate
// search tests one pair per cycle, up to MAX_TERM * MAX_TERM pairs, and a
// hit adds a second small reduction on the same divider. A finished result
// is held in an output register, and the next resolution is taken while it
// waits.
module aspect_ratio_reducer_unit #(
    parameter int MAX_TERM = arr_pkg::ARR_MAX_TERM
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [15:0] width, [31:16] height
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] ratio_w, [31:16] ratio_h
    output logic [1:0]  o_m_tuser    // [1:0] status
);
    import arr_pkg::*;

    localparam int TW = $clog2(MAX_TERM + 1);
    localparam int LW = ARR_DW + TW;
    localparam int PW = LW + PCT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GCHK   = 4'd1;
    localparam logic [3:0] S_GWAIT  = 4'd2;
    localparam logic [3:0] S_DW     = 4'd3;
    localparam logic [3:0] S_DWWAIT = 4'd4;
    localparam logic [3:0] S_DH     = 4'd5;
    localparam logic [3:0] S_DHWAIT = 4'd6;
    localparam logic [3:0] S_EVAL   = 4'd7;
    localparam logic [3:0] S_SRCH   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0]        r_state,  n_state;
    logic              r_phase,  n_phase;
    logic              r_ovalid, n_ovalid;
    logic [ARR_DW-1:0] r_a,      n_a;
    logic [ARR_DW-1:0] r_b,      n_b;
    logic [ARR_DW-1:0] r_num_w,  n_num_w;
    logic [ARR_DW-1:0] r_num_h,  n_num_h;
    logic [ARR_DW-1:0] r_qw,     n_qw;
    logic [ARR_DW-1:0] r_qh,     n_qh;
    logic [TW-1:0]     r_aw,     n_aw;
    logic [TW-1:0]     r_ah,     n_ah;
    logic [LW-1:0]     r_lhs,    n_lhs;
    logic [LW-1:0]     r_rhs,    n_rhs;
    logic [ARR_DW-1:0] r_res_w,  n_res_w;
    logic [ARR_DW-1:0] r_res_h,  n_res_h;
    logic [1:0]        r_res_st, n_res_st;
    logic [31:0]       r_odata,  n_odata;
    logic [1:0]        r_ouser,  n_ouser;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic [ARR_DW-1:0] in_w;
    logic [ARR_DW-1:0] in_h;
    logic [LW-1:0]     diff;
    logic [PW-1:0]     scaled;
    logic              hit;

    assign in_w = i_s_tdata[15:0];
    assign in_h = i_s_tdata[31:16];

    assign diff   = (r_lhs >= r_rhs) ? (r_lhs - r_rhs) : (r_rhs - r_lhs);
    assign scaled = PW'(diff) * PW'(PCT_SCALE);
    assign hit    = scaled < PW'(r_lhs);

    arr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_ovalid = r_ovalid;
        n_a      = r_a;
        n_b      = r_b;
        n_num_w  = r_num_w;
        n_num_h  = r_num_h;
        n_qw     = r_qw;
        n_qh     = r_qh;
        n_aw     = r_aw;
        n_ah     = r_ah;
        n_lhs    = r_lhs;
        n_rhs    = r_rhs;
        n_res_w  = r_res_w;
        n_res_h  = r_res_h;
        n_res_st = r_res_st;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        div_req.start    = 1'b0;
        div_req.dividend = r_a;
        div_req.divisor  = r_b;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_a     = in_w;
                    n_b     = in_h;
                    n_num_w = in_w;
                    n_num_h = in_h;
                    n_phase = 1'b0;
                    if (in_w == '0 || in_h == '0) begin
                        n_res_w  = '0;
                        n_res_h  = '0;
                        n_res_st = ST_ZERO;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_GCHK;
                    end
                end
            end
            S_GCHK: begin
                if (r_b == '0) begin
                    n_state = S_DW;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_GWAIT;
                end
            end
            S_GWAIT: begin
                if (div_rsp.done) begin
                    n_a     = r_b;
                    n_b     = div_rsp.rem;
                    n_state = S_GCHK;
                end
            end
            S_DW: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_num_w;
                div_req.divisor  = r_a;
                n_state          = S_DWWAIT;
            end
            S_DWWAIT: begin
                if (div_rsp.done) begin
                    n_qw    = div_rsp.quot;
                    n_state = S_DH;
                end
            end
            S_DH: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_num_h;
                div_req.divisor  = r_a;
                n_state          = S_DHWAIT;
            end
            S_DHWAIT: begin
                if (div_rsp.done) begin
                    n_qh    = div_rsp.quot;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_phase) begin
                    n_res_w  = r_qw;
                    n_res_h  = r_qh;
                    n_res_st = ST_APPROX;
                    n_state  = S_FIN;
                end else if (r_qw <= ARR_DW'(MAX_TERM)) begin
                    n_res_w  = r_qw;
                    n_res_h  = r_qh;
                    n_res_st = ST_EXACT;
                    n_state  = S_FIN;
                end else begin
                    n_aw    = TW'(MAX_TERM);
                    n_ah    = TW'(MAX_TERM);
                    n_lhs   = LW'(r_qw) * LW'(MAX_TERM);
                    n_rhs   = LW'(r_qh) * LW'(MAX_TERM);
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (hit) begin
                    n_a     = ARR_DW'(r_aw);
                    n_b     = ARR_DW'(r_ah);
                    n_num_w = ARR_DW'(r_aw);
                    n_num_h = ARR_DW'(r_ah);
                    n_phase = 1'b1;
                    n_state = S_GCHK;
                end else if (r_ah == TW'(1)) begin
                    if (r_aw == TW'(1)) begin
                        n_res_w  = '0;
                        n_res_h  = '0;
                        n_res_st = ST_NONE;
                        n_state  = S_FIN;
                    end else begin
                        n_aw  = r_aw - TW'(1);
                        n_ah  = TW'(MAX_TERM);
                        n_rhs = r_rhs - LW'(r_qh);
                        n_lhs = LW'(r_qw) * LW'(MAX_TERM);
                    end
                end else begin
                    n_ah  = r_ah - TW'(1);
                    n_lhs = r_lhs - LW'(r_qw);
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {r_res_h, r_res_w};
                    n_ouser  = r_res_st;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_num_w  <= n_num_w;
        r_num_h  <= n_num_h;
        r_qw     <= n_qw;
        r_qh     <= n_qh;
        r_aw     <= n_aw;
        r_ah     <= n_ah;
        r_lhs    <= n_lhs;
        r_rhs    <= n_rhs;
        r_res_w  <= n_res_w;
        r_res_h  <= n_res_h;
        r_res_st <= n_res_st;
        r_odata  <= n_odata;
        r_ouser  <= n_ouser;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule : aspect_ratio_reducer_unit
`default_nettype wire

// ----- rtl/arr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arr_checker
// Port-level checks of the aspect ratio reducer, bound to the top level.
// ----------------------------------------------------------------------------
module arr_checker #(
    parameter int MAX_TERM = arr_pkg::ARR_MAX_TERM
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [31:0] o_m_tdata,
    input wire [1:0]  o_m_tuser
);
    import arr_pkg::*;

    logic [15:0] rw;
    logic [15:0] rh;

    assign rw = o_m_tdata[15:0];
    assign rh = o_m_tdata[31:16];

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transaction taken while working");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_ZERO || o_m_tuser == ST_NONE) |-> o_m_tdata == 32'd0)
        else $error("flagged result carries a nonzero ratio");

    a_approx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_APPROX |->
            rw != 16'd0 && rh != 16'd0 && rw <= 16'(MAX_TERM) && rh <= 16'(MAX_TERM))
        else $error("approximated ratio outside the search range");

    a_exact_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_EXACT |->
            rw != 16'd0 && rh != 16'd0 && rw <= 16'(MAX_TERM))
        else $error("exact ratio malformed");

endmodule : arr_checker

bind aspect_ratio_reducer_unit arr_checker #(
    .MAX_TERM (MAX_TERM)
) u_arr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

// ----- tb/sv/tb_aspect_ratio_reducer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aspect_ratio_reducer_unit
// Self-checking bench for the aspect ratio reducer. Each accepted resolution
// is run through a local GCD and candidate-search predictor, and the expected
// ratio is queued. Every returned ratio is compared field by field against
// the oldest entry. Directed corner cases come first, then random, near
// standard and tall/narrow resolutions, with random gaps and stalls on both
// stream sides.
// ----------------------------------------------------------------------------
module tb_aspect_ratio_reducer_unit;
    import arr_pkg::*;

    localparam int          MAX_TERM    = ARR_MAX_TERM;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int          DRAIN_WAIT  = 1100;

    typedef struct packed {
        logic [15:0] ratio_w;
        logic [15:0] ratio_h;
        logic [1:0]  status;
    } t_ratio;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data  = '0;
    logic        m_ready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    t_ratio      expected_ratios[$];
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_cnt    = 0;
    int          gap_mode    = 0;
    int          stall_mode  = 0;

    aspect_ratio_reducer_unit #(
        .MAX_TERM(MAX_TERM)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),      // [15:0] width, [31:16] height
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),   // [15:0] ratio_w, [31:16] ratio_h
        .o_m_tuser  (o_m_tuser)    // [1:0] status
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap(input int mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            0: return 0;
            1: begin
                if (r < 60) return 0;
                if (r < 92) return $urandom_range(1, 3);
                return $urandom_range(8, 40);
            end
            default: begin
                if (r < 20) return 0;
                if (r < 70) return $urandom_range(1, 6);
                return $urandom_range(20, 120);
            end
        endcase
    endfunction

    function automatic logic [31:0] euclid_gcd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_ratio reduce_resolution(input logic [15:0] width,
                                                 input logic [15:0] height);
        t_ratio      res;
        logic [31:0] g;
        logic [31:0] w;
        logic [31:0] h;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [63:0] diff;
        int unsigned aw;
        int unsigned ah;
        bit          found;
        res = '0;
        if (width == 0 || height == 0) begin
            res.status = ST_ZERO;
            return res;
        end
        g = euclid_gcd({16'd0, width}, {16'd0, height});
        w = width / g;
        h = height / g;
        if (w <= MAX_TERM) begin
            res.ratio_w = w[15:0];
            res.ratio_h = h[15:0];
            res.status  = ST_EXACT;
            return res;
        end
        res.status = ST_NONE;
        found      = 1'b0;
        for (aw = MAX_TERM; aw > 0 && !found; aw--) begin
            for (ah = MAX_TERM; ah > 0 && !found; ah--) begin
                lhs  = 64'(w) * 64'(ah);
                rhs  = 64'(aw) * 64'(h);
                diff = (lhs > rhs) ? lhs - rhs : rhs - lhs;
                if (64'(PCT_SCALE) * diff < lhs) begin
                    g           = euclid_gcd(aw, ah);
                    res.ratio_w = 16'(aw / g);
                    res.ratio_h = 16'(ah / g);
                    res.status  = ST_APPROX;
                    found       = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic send_resolution(input logic [15:0] width, input logic [15:0] height);
        int unsigned gap;
        gap = pick_gap(gap_mode);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {height, width};
        do @(posedge i_clk); while (!o_s_tready);
        expected_ratios.push_back(reduce_resolution(width, height));
    endtask

    always @(posedge i_clk) begin
        t_ratio exp_r;
        int unsigned gap;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            if (expected_ratios.size() == 0) begin
                $error("ratio transaction with none expected: w=%0d h=%0d status=%0d",
                       o_m_tdata[15:0], o_m_tdata[31:16], o_m_tuser);
                err_count++;
            end else begin
                exp_r = expected_ratios.pop_front();
                if (o_m_tdata[15:0] !== exp_r.ratio_w) begin
                    $error("ratio_w: expected %0d, got %0d", exp_r.ratio_w, o_m_tdata[15:0]);
                    err_count++;
                end
                if (o_m_tdata[31:16] !== exp_r.ratio_h) begin
                    $error("ratio_h: expected %0d, got %0d", exp_r.ratio_h, o_m_tdata[31:16]);
                    err_count++;
                end
                if (o_m_tuser !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_m_tuser);
                    err_count++;
                end
            end
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            gap = pick_gap(stall_mode);
            if (gap == 0) begin
                m_ready <= 1'b1;
            end else begin
                hold_cnt = gap - 1;
                m_ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        gap_mode   = 0;
        stall_mode = 0;
        send_resolution(16'd0, 16'd0);
        send_resolution(16'd0, 16'd1080);
        send_resolution(16'd1920, 16'd0);
        send_resolution(16'd1920, 16'd1080);
        send_resolution(16'd1, 16'd1);
        send_resolution(16'hFFFF, 16'hFFFF);
        send_resolution(16'd1, 16'hFFFF);
        send_resolution(16'd21, 16'd40000);
        send_resolution(16'hFFFF, 16'd1);
        send_resolution(16'd22, 16'd1);
        send_resolution(16'd1366, 16'd768);
        send_resolution(16'd2560, 16'd1080);
        send_resolution(16'd3440, 16'd1440);
        send_resolution(16'd1280, 16'd1024);
        send_resolution(16'd1024, 16'd768);
        send_resolution(16'd65535, 16'd65534);
        send_resolution(16'd46368, 16'd28657);
        send_resolution(16'd1600, 16'd900);
        send_resolution(16'd43, 16'd2);
        send_resolution(16'h5555, 16'hAAAA);
        send_resolution(16'hAAAB, 16'h5555);
    endtask

    task automatic test_random_resolutions();
        gap_mode   = 1;
        stall_mode = 1;
        repeat (200) send_resolution(16'($urandom), 16'($urandom));
    endtask

    task automatic test_near_standard_ratios();
        int unsigned aw;
        int unsigned ah;
        int unsigned k;
        int          wv;
        int          hv;
        gap_mode   = 1;
        stall_mode = 2;
        repeat (200) begin
            aw = $urandom_range(1, MAX_TERM);
            ah = $urandom_range(1, MAX_TERM);
            k  = $urandom_range(1, 65535 / ((aw > ah) ? aw : ah));
            wv = aw * k;
            hv = ah * k;
            if ($urandom_range(0, 2) != 0) begin
                wv = wv + $urandom_range(0, 6) - 3;
                hv = hv + $urandom_range(0, 2) - 1;
            end
            wv = (wv < 0) ? 0 : (wv > 65535) ? 65535 : wv;
            hv = (hv < 0) ? 0 : (hv > 65535) ? 65535 : hv;
            send_resolution(16'(wv), 16'(hv));
        end
    endtask

    task automatic test_tall_and_narrow();
        int unsigned r;
        logic [15:0] wv;
        logic [15:0] hv;
        gap_mode   = 2;
        stall_mode = 0;
        repeat (160) begin
            if (cycle_count[0]) stall_mode = 1;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                wv = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom);
                hv = (wv == 0) ? 16'($urandom) : 16'd0;
            end else if (r < 45) begin
                wv = 16'($urandom_range(1, 30));
                hv = 16'($urandom);
            end else if (r < 80) begin
                wv = 16'($urandom);
                hv = 16'($urandom_range(1, 30));
            end else begin
                wv = 16'($urandom_range(1, MAX_TERM) * $urandom_range(1, 3000));
                hv = 16'($urandom_range(1, 65535));
            end
            send_resolution(wv, hv);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_resolutions();
        test_near_standard_ratios();
        test_tall_and_narrow();
        s_valid <= 1'b0;
        while (expected_ratios.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0 && expected_ratios.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- aspect_ratio_reducer_unit.f -----
rtl/arr_pkg.sv
rtl/arr_div.sv
rtl/aspect_ratio_reducer_unit.sv
rtl/arr_checker.sv
tb/sv/tb_aspect_ratio_reducer_unit.sv
